/* sv/correlation_descriptor_table_core_defines.svh */
// ---------------------------------------------------------------------------
// Correlation descriptor table assertion macros
// Shared concurrent assertion forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef CORRELATION_DESCRIPTOR_TABLE_CORE_DEFINES_SVH
`define CORRELATION_DESCRIPTOR_TABLE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cdt_pkg.sv */
// ---------------------------------------------------------------------------
// Correlation descriptor table package
// Field widths, operation and status codes, and the command record.
// ---------------------------------------------------------------------------
package cdt_pkg;

    localparam int FUNC_W     = 3;
    localparam int KEY_W      = 64;
    localparam int DESC_IN_W  = 8;
    localparam int DESC_OUT_W = 7;
    localparam int STATUS_W   = 3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [FUNC_W-1:0] FN_MAP     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_EXTRACT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LOOKUP  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_NOT_POSITIVE = 3'd2,
        ST_BEYOND_USED  = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_MAP,
        OP_EXTRACT,
        OP_REMOVE,
        OP_LOOKUP,
        OP_CLEAR,
        OP_NONE
    } t_op;

    // Classified command as it travels from the front end to the back end.
    typedef struct packed {
        t_op                   op;
        logic [KEY_W-1:0]      key_high;
        logic [KEY_W-1:0]      key_low;
        logic [DESC_OUT_W-1:0] desc;
        logic                  desc_bad;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* sv/cdt_front.sv */
// ---------------------------------------------------------------------------
// Correlation descriptor table front end
// Accepts items, decodes the operation and pre-checks the descriptor sign.
// ---------------------------------------------------------------------------
module cdt_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic        [cdt_pkg::FUNC_W-1:0]     i_func,
    input  logic        [cdt_pkg::KEY_W-1:0]      i_key_high,
    input  logic        [cdt_pkg::KEY_W-1:0]      i_key_low,
    input  logic signed [cdt_pkg::DESC_IN_W-1:0]  i_descriptor_in,
    input  cdt_pkg::t_q_status                    i_q_stat,
    output logic                                  o_push,
    output cdt_pkg::t_cmd                         o_cmd
);

    logic          r_f_valid;
    cdt_pkg::t_cmd r_f_cmd;
    logic          n_f_valid;
    cdt_pkg::t_cmd n_f_cmd;
    logic          accept;

    assign o_push  = r_f_valid && !i_q_stat.full;
    assign o_stall = r_f_valid && i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_cmd   = r_f_cmd;

    always_comb begin
        n_f_cmd          = r_f_cmd;
        n_f_valid        = r_f_valid;
        if (o_push) begin
            n_f_valid = 1'b0;
        end
        if (accept) begin
            n_f_valid        = 1'b1;
            n_f_cmd.key_high = i_key_high;
            n_f_cmd.key_low  = i_key_low;
            n_f_cmd.desc     = i_descriptor_in[cdt_pkg::DESC_OUT_W-1:0];
            // A descriptor of zero or with the sign bit set is never valid.
            n_f_cmd.desc_bad = (i_descriptor_in == 8'sd0) ||
                               i_descriptor_in[cdt_pkg::DESC_IN_W-1];
            unique case (i_func)
                cdt_pkg::FN_MAP:     n_f_cmd.op = cdt_pkg::OP_MAP;
                cdt_pkg::FN_EXTRACT: n_f_cmd.op = cdt_pkg::OP_EXTRACT;
                cdt_pkg::FN_REMOVE:  n_f_cmd.op = cdt_pkg::OP_REMOVE;
                cdt_pkg::FN_LOOKUP:  n_f_cmd.op = cdt_pkg::OP_LOOKUP;
                cdt_pkg::FN_CLEAR:   n_f_cmd.op = cdt_pkg::OP_CLEAR;
                default:             n_f_cmd.op = cdt_pkg::OP_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= n_f_valid;
        end
        r_f_cmd <= n_f_cmd;
    end

endmodule

/* sv/cdt_queue.sv */
// ---------------------------------------------------------------------------
// Correlation descriptor table command queue
// Short FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module cdt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cdt_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output cdt_pkg::t_cmd      o_cmd,
    output cdt_pkg::t_q_status o_stat
);

    cdt_pkg::t_cmd                r_q [cdt_pkg::Q_DEPTH];
    logic [cdt_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [cdt_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [cdt_pkg::Q_CNT_W-1:0]  r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_stat.full  = (r_count == cdt_pkg::Q_CNT_W'(cdt_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + cdt_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + cdt_pkg::Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + cdt_pkg::Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - cdt_pkg::Q_CNT_W'(1);
            end
        end
        if (do_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* sv/cdt_back.sv */
// ---------------------------------------------------------------------------
// Correlation descriptor table back end
// Slot memory, scan sequencer and result register.
// ---------------------------------------------------------------------------
module cdt_back #(
    parameter int ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cdt_pkg::t_q_status                i_q_stat,
    input  cdt_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cdt_pkg::STATUS_W-1:0]      o_status,
    output logic [cdt_pkg::DESC_OUT_W-1:0]    o_descriptor_out,
    output logic [cdt_pkg::KEY_W-1:0]         o_found_key_high,
    output logic [cdt_pkg::KEY_W-1:0]         o_found_key_low,
    output logic                              o_is_empty
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UL_W  = $clog2(ENTRIES + 1);
    localparam int DW    = cdt_pkg::DESC_OUT_W;
    localparam int KW    = cdt_pkg::KEY_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Slot memory; entries never written since reset read as the zero key.
    logic [KW-1:0]    r_mem_hi [ENTRIES];
    logic [KW-1:0]    r_mem_lo [ENTRIES];
    logic             r_vld    [ENTRIES];
    logic [KW-1:0]    r_rd_hi;
    logic [KW-1:0]    r_rd_lo;
    logic             r_rd_live;

    t_state           r_state,    n_state;
    cdt_pkg::t_cmd    r_cmd,      n_cmd;
    logic [UL_W-1:0]  r_addr,     n_addr;
    logic [UL_W-1:0]  r_used,     n_used;
    logic             r_rd_ok,    n_rd_ok;
    logic [IDX_W-1:0] r_rd_idx,   n_rd_idx;
    logic             r_hit,      n_hit;
    logic [IDX_W-1:0] r_hit_idx,  n_hit_idx;
    logic             r_free,     n_free;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic [UL_W-1:0]  r_nz_cnt,   n_nz_cnt;
    logic             r_tgt_nz,   n_tgt_nz;
    logic [KW-1:0]    r_look_hi,  n_look_hi;
    logic [KW-1:0]    r_look_lo,  n_look_lo;

    logic             r_o_valid,  n_o_valid;
    cdt_pkg::t_status r_o_status, n_o_status;
    logic [DW-1:0]    r_o_desc,   n_o_desc;
    logic [KW-1:0]    r_o_fhi,    n_o_fhi;
    logic [KW-1:0]    r_o_flo,    n_o_flo;
    logic             r_o_empty,  n_o_empty;

    logic             issue;
    logic             out_free;
    logic             done_fire;
    logic [KW-1:0]    eff_hi;
    logic [KW-1:0]    eff_lo;
    logic             rd_zero;
    logic             rd_match;
    logic             rd_tgt;
    logic [DW-1:0]    desc_m1;
    logic             key_nz;
    logic             room;
    logic             beyond;

    // Result of the operation, valid in the done state.
    logic             we;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_zero;
    cdt_pkg::t_status res_status;
    logic [DW-1:0]    res_desc;
    logic [KW-1:0]    res_fhi;
    logic [KW-1:0]    res_flo;
    logic [UL_W-1:0]  res_used;
    logic             res_add;
    logic             res_sub;
    logic             res_clear;

    assign issue     = (r_state == S_SCAN) && (r_addr < r_used);
    assign out_free  = !r_o_valid || !i_stall;
    assign done_fire = (r_state == S_DONE) && out_free;
    assign o_pop     = (r_state == S_IDLE) && !i_q_stat.empty;

    assign eff_hi   = r_rd_live ? r_rd_hi : '0;
    assign eff_lo   = r_rd_live ? r_rd_lo : '0;
    assign rd_zero  = (eff_hi == '0) && (eff_lo == '0);
    assign rd_match = (eff_hi == r_cmd.key_high) && (eff_lo == r_cmd.key_low);
    assign desc_m1  = r_cmd.desc - DW'(1);
    assign rd_tgt   = (DW'(r_rd_idx) == desc_m1);
    assign key_nz   = (r_cmd.key_high != '0) || (r_cmd.key_low != '0);
    assign room     = (r_used < UL_W'(ENTRIES));
    assign beyond   = (r_cmd.desc > DW'(r_used));

    // Outcome of the command from the scan summary.
    always_comb begin
        we         = 1'b0;
        wr_idx     = '0;
        wr_zero    = 1'b0;
        res_status = cdt_pkg::ST_OK;
        res_desc   = '0;
        res_fhi    = '0;
        res_flo    = '0;
        res_used   = r_used;
        res_add    = 1'b0;
        res_sub    = 1'b0;
        res_clear  = 1'b0;
        unique case (r_cmd.op)
            cdt_pkg::OP_MAP: begin
                if (r_hit) begin
                    we       = 1'b1;
                    wr_idx   = r_hit_idx;
                    res_desc = DW'(r_hit_idx) + DW'(1);
                end else if (r_free) begin
                    we       = 1'b1;
                    wr_idx   = r_free_idx;
                    res_desc = DW'(r_free_idx) + DW'(1);
                    res_add  = key_nz;
                end else if (room) begin
                    we       = 1'b1;
                    wr_idx   = r_used[IDX_W-1:0];
                    res_used = r_used + UL_W'(1);
                    res_desc = DW'(r_used) + DW'(1);
                    res_add  = key_nz;
                end else begin
                    res_status = cdt_pkg::ST_FULL;
                end
            end
            cdt_pkg::OP_EXTRACT: begin
                if (r_hit) begin
                    we       = 1'b1;
                    wr_idx   = r_hit_idx;
                    wr_zero  = 1'b1;
                    res_desc = DW'(r_hit_idx) + DW'(1);
                    res_sub  = key_nz;
                end else begin
                    res_status = cdt_pkg::ST_NOT_FOUND;
                end
            end
            cdt_pkg::OP_REMOVE: begin
                if (r_cmd.desc_bad) begin
                    res_status = cdt_pkg::ST_NOT_POSITIVE;
                end else if (beyond) begin
                    res_status = cdt_pkg::ST_BEYOND_USED;
                end else begin
                    we      = 1'b1;
                    wr_idx  = desc_m1[IDX_W-1:0];
                    wr_zero = 1'b1;
                    res_sub = r_tgt_nz;
                end
            end
            cdt_pkg::OP_LOOKUP: begin
                if (r_cmd.desc_bad) begin
                    res_status = cdt_pkg::ST_NOT_POSITIVE;
                end else if (beyond) begin
                    res_status = cdt_pkg::ST_BEYOND_USED;
                end else begin
                    res_fhi = r_look_hi;
                    res_flo = r_look_lo;
                end
            end
            cdt_pkg::OP_CLEAR: begin
                res_used  = '0;
                res_clear = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer: pop, scan the used slots, then finish and write back.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_used     = r_used;
        n_rd_ok    = issue;
        n_rd_idx   = r_addr[IDX_W-1:0];
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_nz_cnt   = r_nz_cnt;
        n_tgt_nz   = r_tgt_nz;
        n_look_hi  = r_look_hi;
        n_look_lo  = r_look_lo;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_desc   = r_o_desc;
        n_o_fhi    = r_o_fhi;
        n_o_flo    = r_o_flo;
        n_o_empty  = r_o_empty;

        if (r_rd_ok) begin
            if (rd_match && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_rd_idx;
            end
            if (rd_zero && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_rd_idx;
            end
            if (!rd_zero) begin
                n_nz_cnt = r_nz_cnt + UL_W'(1);
            end
            if (rd_tgt) begin
                n_tgt_nz  = !rd_zero;
                n_look_hi = eff_hi;
                n_look_lo = eff_lo;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_cmd    = i_cmd;
                    n_addr   = '0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    n_nz_cnt = '0;
                    n_tgt_nz = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_addr = r_addr + UL_W'(1);
                end else if (!r_rd_ok) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_used     = res_used;
                    n_o_valid  = 1'b1;
                    n_o_status = res_status;
                    n_o_desc   = res_desc;
                    n_o_fhi    = res_fhi;
                    n_o_flo    = res_flo;
                    // Only one slot changes, so the count of occupied slots
                    // moves by at most one.
                    n_o_empty  = res_clear ||
                                 ((r_nz_cnt == '0) && !res_add) ||
                                 ((r_nz_cnt == UL_W'(1)) && res_sub);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_rd_ok   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_rd_ok   <= n_rd_ok;
            r_o_valid <= n_o_valid;
        end
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_nz_cnt   <= n_nz_cnt;
        r_tgt_nz   <= n_tgt_nz;
        r_look_hi  <= n_look_hi;
        r_look_lo  <= n_look_lo;
        r_o_status <= n_o_status;
        r_o_desc   <= n_o_desc;
        r_o_fhi    <= n_o_fhi;
        r_o_flo    <= n_o_flo;
        r_o_empty  <= n_o_empty;
    end

    // Slot valid bits: cleared together at reset, set by any write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (done_fire && we) begin
            r_vld[wr_idx] <= 1'b1;
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (done_fire && we) begin
            r_mem_hi[wr_idx] <= wr_zero ? '0 : r_cmd.key_high;
            r_mem_lo[wr_idx] <= wr_zero ? '0 : r_cmd.key_low;
        end
        if (issue) begin
            r_rd_hi   <= r_mem_hi[r_addr[IDX_W-1:0]];
            r_rd_lo   <= r_mem_lo[r_addr[IDX_W-1:0]];
            r_rd_live <= r_vld[r_addr[IDX_W-1:0]];
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_descriptor_out = r_o_desc;
    assign o_found_key_high = r_o_fhi;
    assign o_found_key_low  = r_o_flo;
    assign o_is_empty       = r_o_empty;

endmodule

/* sv/correlation_descriptor_table_core.sv */
// An accepted item passes through the front register, the queue, the pop, the
// slot scan and the finish before its result is registered. The back end takes
// one command at a time; its pace is set by the slot scan, which reads one slot
// per cycle through one read port.
// Reset: synchronous, active low; the used length drops to zero and every slot
// reads as the zero key at once through per-slot valid bits, with no clearing pass.
// ---------------------------------------------------------------------------
// Correlation descriptor table core
// Maps 128-bit correlation keys to small descriptors (slot index plus one).
// ---------------------------------------------------------------------------
//
// The design is split in two halves joined by a two-item command queue.
//
// The front end registers each accepted item and decodes the function code
// into an operation. It also flags descriptors that are zero or negative, so
// the back end only has to compare against the used length.
//
// The back end holds the slot memory. For every command it sweeps the slots
// below the used length, one per cycle, and collects a summary: the lowest
// slot holding the key, the lowest free slot, the number of occupied slots,
// and the contents of the slot named by the descriptor. A finish cycle then
// decides the outcome, performs the single slot write the operation needs,
// updates the used length and loads the result register. Whether the table
// is empty afterwards follows from the occupied count, since an operation
// changes at most one slot.
//
// The result register sits between the back end and the output channel, so
// new items keep flowing into the front end and queue while a result waits, until the queue fills.
module correlation_descriptor_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic        [cdt_pkg::FUNC_W-1:0]     i_func,
    input  logic        [cdt_pkg::KEY_W-1:0]      i_key_high,
    input  logic        [cdt_pkg::KEY_W-1:0]      i_key_low,
    input  logic signed [cdt_pkg::DESC_IN_W-1:0]  i_descriptor_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic        [cdt_pkg::STATUS_W-1:0]   o_status,
    output logic        [cdt_pkg::DESC_OUT_W-1:0] o_descriptor_out,
    output logic        [cdt_pkg::KEY_W-1:0]      o_found_key_high,
    output logic        [cdt_pkg::KEY_W-1:0]      o_found_key_low,
    output logic                                  o_is_empty
);

    cdt_pkg::t_q_status q_stat;
    cdt_pkg::t_cmd      front_cmd;
    cdt_pkg::t_cmd      queue_cmd;
    logic               push;
    logic               pop;

    cdt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_key_high      (i_key_high),
        .i_key_low       (i_key_low),
        .i_descriptor_in (i_descriptor_in),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    cdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    cdt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_stat         (q_stat),
        .i_cmd            (queue_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_descriptor_out (o_descriptor_out),
        .o_found_key_high (o_found_key_high),
        .o_found_key_low  (o_found_key_low),
        .o_is_empty       (o_is_empty)
    );

endmodule

/* sv/cdt_checker.sv */
// ---------------------------------------------------------------------------
// Correlation descriptor table port checker
// Watches the top-level ports and checks result consistency over time.
// ---------------------------------------------------------------------------
`include "correlation_descriptor_table_core_defines.svh"

module cdt_checker #(
    parameter int ENTRIES = 16
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_stall,
    input logic        [cdt_pkg::FUNC_W-1:0]     i_func,
    input logic        [cdt_pkg::KEY_W-1:0]      i_key_high,
    input logic        [cdt_pkg::KEY_W-1:0]      i_key_low,
    input logic signed [cdt_pkg::DESC_IN_W-1:0]  i_descriptor_in,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic        [cdt_pkg::STATUS_W-1:0]   o_status,
    input logic        [cdt_pkg::DESC_OUT_W-1:0] o_descriptor_out,
    input logic        [cdt_pkg::KEY_W-1:0]      o_found_key_high,
    input logic        [cdt_pkg::KEY_W-1:0]      o_found_key_low,
    input logic                                  o_is_empty
);

    logic key_seen;
    logic desc_cap;

    assign key_seen = (o_found_key_high != '0) || (o_found_key_low != '0);
    assign desc_cap = (o_descriptor_out <= cdt_pkg::DESC_OUT_W'(ENTRIES));

    // A stalled result holds its status and descriptor until it is taken.
    `CDT_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_descriptor_out), "stalled result changed")

    // Failed operations never hand out a descriptor.
    `CDT_ASSERT_NOW(a_err_no_desc, o_valid && (o_status != cdt_pkg::ST_OK), o_descriptor_out == '0, "descriptor on error")

    // Only a successful lookup returns a key, and lookup gives no descriptor.
    `CDT_ASSERT_NOW(a_key_only_lookup, o_valid && key_seen, (o_status == cdt_pkg::ST_OK) && (o_descriptor_out == '0), "key on wrong result")

    // A returned descriptor names a real slot.
    `CDT_ASSERT_NOW(a_desc_range, o_valid && (o_descriptor_out != '0), desc_cap, "descriptor out of range")

endmodule

bind correlation_descriptor_table_core cdt_checker #(.ENTRIES(ENTRIES)) u_cdt_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Correlation descriptor table core testbench
// Drives map, extract, remove, lookup, clear and spare function items through
// the valid/stall channels and checks every result against a cycle-free
// model of the slot table kept inside the bench, or a hand-typed answer.
// ---------------------------------------------------------------------------
module testbench;

    // The block is built with its default table size; the model follows it.
    localparam int ENTRIES      = 16;
    localparam int KEY_POOL     = 20;
    localparam int RANDOM_ITEMS = 1400;
    // Longest run of cycles with no item moving on either channel. The long
    // receiver hold-off below is the worst case and this is well above it.
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 40;

    // Function codes that the block decodes as no operation.
    localparam logic [cdt_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd5;
    localparam logic [cdt_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd6;
    localparam logic [cdt_pkg::FUNC_W-1:0] FN_SPARE_C = 3'd7;

    // One result item, in the order of the output ports.
    typedef struct packed {
        logic [cdt_pkg::STATUS_W-1:0]   status;
        logic [cdt_pkg::DESC_OUT_W-1:0] desc;
        logic [cdt_pkg::KEY_W-1:0]      key_high;
        logic [cdt_pkg::KEY_W-1:0]      key_low;
        logic                           empty;
    } t_answer;

    // One input item. A fixed row carries its answer typed in by hand.
    typedef struct {
        logic [cdt_pkg::FUNC_W-1:0]           func;
        logic [cdt_pkg::KEY_W-1:0]            key_high;
        logic [cdt_pkg::KEY_W-1:0]            key_low;
        logic signed [cdt_pkg::DESC_IN_W-1:0] desc;
        bit                                   fixed;
        t_answer                              answer;
    } t_item;

    logic                                 i_clk           = 1'b0;
    logic                                 i_rst_n         = 1'b0;
    logic                                 i_valid         = 1'b0;
    logic                                 o_stall;
    logic [cdt_pkg::FUNC_W-1:0]           i_func          = cdt_pkg::FN_MAP;
    logic [cdt_pkg::KEY_W-1:0]            i_key_high      = '0;
    logic [cdt_pkg::KEY_W-1:0]            i_key_low       = '0;
    logic signed [cdt_pkg::DESC_IN_W-1:0] i_descriptor_in = '0;
    logic                                 o_valid;
    logic                                 i_stall         = 1'b0;
    logic [cdt_pkg::STATUS_W-1:0]         o_status;
    logic [cdt_pkg::DESC_OUT_W-1:0]       o_descriptor_out;
    logic [cdt_pkg::KEY_W-1:0]            o_found_key_high;
    logic [cdt_pkg::KEY_W-1:0]            o_found_key_low;
    logic                                 o_is_empty;

    // Model of the slot table.
    logic [cdt_pkg::KEY_W-1:0] slot_high [ENTRIES];
    logic [cdt_pkg::KEY_W-1:0] slot_low  [ENTRIES];
    int                        used_len;

    // Stimulus list and the answers still owed by the block, oldest first.
    t_item   stim_items[$];
    t_answer answers_due[$];
    t_answer want;

    logic [cdt_pkg::KEY_W-1:0] pool_high [KEY_POOL];
    logic [cdt_pkg::KEY_W-1:0] pool_low  [KEY_POOL];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    bit  hold_done    = 1'b0;

    always #2 i_clk = ~i_clk;

    correlation_descriptor_table_core #(
        .ENTRIES (ENTRIES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_key_high       (i_key_high),
        .i_key_low        (i_key_low),
        .i_descriptor_in  (i_descriptor_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_descriptor_out (o_descriptor_out),
        .o_found_key_high (o_found_key_high),
        .o_found_key_low  (o_found_key_low),
        .o_is_empty       (o_is_empty)
    );

    // -----------------------------------------------------------------------
    // Table model
    // -----------------------------------------------------------------------

    // Lowest slot below the used length holding the key, ENTRIES when none.
    function automatic int find_slot(logic [cdt_pkg::KEY_W-1:0] khi,
                                     logic [cdt_pkg::KEY_W-1:0] klo);
        for (int i = 0; i < used_len; i++) begin
            if (slot_high[i] == khi && slot_low[i] == klo) begin
                return i;
            end
        end
        return ENTRIES;
    endfunction

    function automatic bit table_is_free();
        for (int i = 0; i < used_len; i++) begin
            if (slot_high[i] != '0 || slot_low[i] != '0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Descriptors are read as raw 8-bit values: zero or a set sign bit is
    // not positive, anything past the used length is out of range.
    function automatic logic [cdt_pkg::STATUS_W-1:0] desc_status(
            logic [cdt_pkg::DESC_IN_W-1:0] d, output int slot);
        slot = 0;
        if (d == '0 || d[cdt_pkg::DESC_IN_W-1]) begin
            return cdt_pkg::ST_NOT_POSITIVE;
        end
        if (int'(d) > used_len) begin
            return cdt_pkg::ST_BEYOND_USED;
        end
        slot = int'(d) - 1;
        return cdt_pkg::ST_OK;
    endfunction

    // Applies one item to the model and returns the result it gives.
    function automatic t_answer table_apply(logic [cdt_pkg::FUNC_W-1:0] func,
                                            logic [cdt_pkg::KEY_W-1:0] khi,
                                            logic [cdt_pkg::KEY_W-1:0] klo,
                                            logic [cdt_pkg::DESC_IN_W-1:0] d);
        t_answer a;
        int      idx;
        int      slot;
        a = '0;
        a.status = cdt_pkg::ST_OK;
        case (func)
            cdt_pkg::FN_MAP: begin
                // A stored copy wins, then the lowest free slot, then append.
                idx = find_slot(khi, klo);
                if (idx == ENTRIES) begin
                    idx = find_slot('0, '0);
                end
                if (idx < ENTRIES) begin
                    slot_high[idx] = khi;
                    slot_low[idx]  = klo;
                    a.desc = cdt_pkg::DESC_OUT_W'(idx + 1);
                end else if (used_len < ENTRIES) begin
                    slot_high[used_len] = khi;
                    slot_low[used_len]  = klo;
                    used_len = used_len + 1;
                    a.desc = cdt_pkg::DESC_OUT_W'(used_len);
                end else begin
                    a.status = cdt_pkg::ST_FULL;
                end
            end
            cdt_pkg::FN_EXTRACT: begin
                idx = find_slot(khi, klo);
                if (idx < ENTRIES) begin
                    slot_high[idx] = '0;
                    slot_low[idx]  = '0;
                    a.desc = cdt_pkg::DESC_OUT_W'(idx + 1);
                end else begin
                    a.status = cdt_pkg::ST_NOT_FOUND;
                end
            end
            cdt_pkg::FN_REMOVE: begin
                a.status = desc_status(d, slot);
                if (a.status == cdt_pkg::ST_OK) begin
                    slot_high[slot] = '0;
                    slot_low[slot]  = '0;
                end
            end
            cdt_pkg::FN_LOOKUP: begin
                a.status = desc_status(d, slot);
                if (a.status == cdt_pkg::ST_OK) begin
                    a.key_high = slot_high[slot];
                    a.key_low  = slot_low[slot];
                end
            end
            cdt_pkg::FN_CLEAR: begin
                used_len = 0;
            end
            default: begin
            end
        endcase
        a.empty = table_is_free();
        return a;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus construction
    // -----------------------------------------------------------------------

    // Appends reps items; each repeat bumps the low key half so that a row
    // can fill the table with distinct keys. A fixed row carries its answer.
    task automatic add_row(logic [cdt_pkg::FUNC_W-1:0] func,
                           logic [cdt_pkg::KEY_W-1:0] khi,
                           logic [cdt_pkg::KEY_W-1:0] klo,
                           logic signed [cdt_pkg::DESC_IN_W-1:0] d,
                           int reps = 1, bit fixed = 1'b0,
                           logic [cdt_pkg::STATUS_W-1:0] st = cdt_pkg::ST_OK,
                           logic [cdt_pkg::DESC_OUT_W-1:0] dout = '0,
                           logic empty = 1'b0);
        t_item it;
        it.func     = func;
        it.key_high = khi;
        it.desc     = d;
        it.fixed    = fixed;
        it.answer   = '{status: st, desc: dout, key_high: '0, key_low: '0,
                        empty: empty};
        for (int r = 0; r < reps; r++) begin
            it.key_low = klo + cdt_pkg::KEY_W'(r);
            stim_items.insert(stim_items.size(), it);
        end
    endtask

    task automatic pick_key(output logic [cdt_pkg::KEY_W-1:0] khi,
                            output logic [cdt_pkg::KEY_W-1:0] klo);
        int k;
        if ($urandom_range(0, 99) < 88) begin
            k   = $urandom_range(0, KEY_POOL - 1);
            khi = pool_high[k];
            klo = pool_low[k];
        end else begin
            khi = {$urandom, $urandom};
            klo = {$urandom, $urandom};
        end
    endtask

    // Mostly descriptors that land inside the table, some random bytes and
    // the signed corners.
    function automatic logic signed [cdt_pkg::DESC_IN_W-1:0] pick_desc();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return cdt_pkg::DESC_IN_W'($urandom_range(1, ENTRIES + 1));
        end
        if (r < 90) begin
            return cdt_pkg::DESC_IN_W'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 3))
            0:       return 8'sd0;
            1:       return -8'sd1;
            2:       return 8'sd127;
            default: return -8'sd128;
        endcase
    endfunction

    task automatic build_directed();
        logic [cdt_pkg::KEY_W-1:0] ones;
        ones = '1;
        // Error codes straight out of reset: nothing is used yet.
        add_row(cdt_pkg::FN_LOOKUP, '0, '0, 8'sd1, 1, 1'b1,
                cdt_pkg::ST_BEYOND_USED, 7'd0, 1'b1);
        add_row(cdt_pkg::FN_REMOVE, '0, '0, 8'sd0, 1, 1'b1,
                cdt_pkg::ST_NOT_POSITIVE, 7'd0, 1'b1);
        add_row(cdt_pkg::FN_LOOKUP, '0, '0, -8'sd128, 1, 1'b1,
                cdt_pkg::ST_NOT_POSITIVE, 7'd0, 1'b1);
        add_row(cdt_pkg::FN_REMOVE, '0, '0, 8'sd127, 1, 1'b1,
                cdt_pkg::ST_BEYOND_USED, 7'd0, 1'b1);
        add_row(cdt_pkg::FN_EXTRACT, ones, ones, 8'sd0, 1, 1'b1,
                cdt_pkg::ST_NOT_FOUND, 7'd0, 1'b1);
        // A zero key appends a free slot, which the next map then takes.
        add_row(cdt_pkg::FN_MAP, '0, '0, 8'sd0, 1, 1'b1, cdt_pkg::ST_OK, 7'd1, 1'b1);
        add_row(cdt_pkg::FN_MAP, ones, ones, 8'sd0, 1, 1'b1, cdt_pkg::ST_OK, 7'd1, 1'b0);
        add_row(cdt_pkg::FN_MAP, '0, 64'd1, 8'sd0);
        add_row(cdt_pkg::FN_MAP, ones, ones, 8'sd0);
        add_row(cdt_pkg::FN_LOOKUP, '0, '0, 8'sd2);
        // Zero key extract with no free slot, then with one.
        add_row(cdt_pkg::FN_EXTRACT, '0, '0, 8'sd0);
        add_row(cdt_pkg::FN_REMOVE, '0, '0, 8'sd2);
        add_row(cdt_pkg::FN_EXTRACT, '0, '0, 8'sd0);
        add_row(cdt_pkg::FN_LOOKUP, '0, '0, 8'sd2);
        add_row(cdt_pkg::FN_MAP, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 8'sd0);
        add_row(FN_SPARE_A, ones, ones, 8'sd1);
        add_row(FN_SPARE_B, '0, '0, -8'sd1);
        add_row(FN_SPARE_C, ones, '0, 8'sd3);
        // Fill the rest of the table, then one more distinct key is refused.
        add_row(cdt_pkg::FN_MAP, 64'h8000_0000_0000_0000, 64'h10, 8'sd0, ENTRIES - 2);
        add_row(cdt_pkg::FN_MAP, 64'h1234, 64'h5678, 8'sd0, 1, 1'b1,
                cdt_pkg::ST_FULL, 7'd0, 1'b0);
        add_row(cdt_pkg::FN_EXTRACT, ones, ones, 8'sd0);
        add_row(cdt_pkg::FN_MAP, '0, '0, 8'sd0);
        add_row(cdt_pkg::FN_LOOKUP, '0, '0, 8'sd16);
        add_row(cdt_pkg::FN_LOOKUP, '0, '0, 8'sd17);
        // Clear keeps the slots but drops the mark; an append rewrites.
        add_row(cdt_pkg::FN_CLEAR, ones, ones, 8'sd5, 1, 1'b1, cdt_pkg::ST_OK, 7'd0, 1'b1);
        add_row(cdt_pkg::FN_MAP, 64'h0F0F, 64'hF0F0, 8'sd0);
        add_row(cdt_pkg::FN_LOOKUP, '0, '0, 8'sd2);
    endtask

    // Random items in short sequences: mixed traffic, fill runs that reach a
    // full table, drain runs that free slots, and unstructured noise.
    task automatic build_random();
        int                                   counted;
        int                                   kind;
        int                                   len;
        int                                   r;
        logic [cdt_pkg::FUNC_W-1:0]           func;
        logic [cdt_pkg::KEY_W-1:0]            khi;
        logic [cdt_pkg::KEY_W-1:0]            klo;
        logic signed [cdt_pkg::DESC_IN_W-1:0] d;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(5, 30);
            if (kind >= 45 && kind < 70 && $urandom_range(0, 1) == 0) begin
                add_row(cdt_pkg::FN_CLEAR, '0, '0, pick_desc());
                counted++;
            end
            for (int n = 0; n < len; n++) begin
                pick_key(khi, klo);
                d = pick_desc();
                if (kind < 45) begin
                    r = $urandom_range(0, 99);
                    if (r < 40)      func = cdt_pkg::FN_MAP;
                    else if (r < 60) func = cdt_pkg::FN_EXTRACT;
                    else if (r < 72) func = cdt_pkg::FN_REMOVE;
                    else if (r < 90) func = cdt_pkg::FN_LOOKUP;
                    else if (r < 94) func = cdt_pkg::FN_CLEAR;
                    else             func = FN_SPARE_A +
                                            cdt_pkg::FUNC_W'($urandom_range(0, 2));
                end else if (kind < 70) begin
                    func = (n + 3 < len) ? cdt_pkg::FN_MAP : cdt_pkg::FN_LOOKUP;
                end else if (kind < 85) begin
                    func = ($urandom_range(0, 2) == 0) ? cdt_pkg::FN_REMOVE
                                                       : cdt_pkg::FN_EXTRACT;
                end else begin
                    func = cdt_pkg::FUNC_W'($urandom_range(0, 7));
                    khi  = {$urandom, $urandom};
                    klo  = {$urandom, $urandom};
                    d    = cdt_pkg::DESC_IN_W'($urandom);
                end
                add_row(func, khi, klo, d);
                if (func <= cdt_pkg::FN_CLEAR) begin
                    counted++;
                end
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [cdt_pkg::KEY_W-1:0] got,
                                   logic [cdt_pkg::KEY_W-1:0] wanted);
        $display("result %0d: %s: got %h, wanted %h", results_seen, what, got, wanted);
        mismatches++;
    endtask

    // Every result that leaves the block is matched against the oldest answer
    // still owed. Outputs are sampled at the rising edge, before the block's
    // own registers move.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0, '0);
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_descriptor_out !== want.desc)
                    report_mismatch("descriptor_out", o_descriptor_out, want.desc);
                if (o_found_key_high !== want.key_high)
                    report_mismatch("found_key_high", o_found_key_high, want.key_high);
                if (o_found_key_low !== want.key_low)
                    report_mismatch("found_key_low", o_found_key_low, want.key_low);
                if (o_is_empty !== want.empty)
                    report_mismatch("is_empty", o_is_empty, want.empty);
            end
            results_seen++;
        end
    end

    // The run is stopped if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver
    // -----------------------------------------------------------------------

    // The receiver switches between stretches of no stalls, light and heavy
    // random stalls, and a fixed two-in-five pattern. Once, after enough
    // results, it holds off for a long stretch so that the command queue
    // fills and the block stalls its input while the sender keeps offering.
    initial begin : receiver
        int mode;
        int len;
        int tick;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(20, 200);
            repeat (len) begin
                @(posedge i_clk);
                tick++;
                if (!hold_done && results_seen >= HOLD_AFTER) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        0:       i_stall <= 1'b0;
                        1:       i_stall <= ($urandom_range(0, 99) < 30);
                        2:       i_stall <= ((tick % 5) < 2);
                        default: i_stall <= ($urandom_range(0, 99) < 75);
                    endcase
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sender and run control
    // -----------------------------------------------------------------------

    initial begin : sender
        t_item   it;
        t_answer got;
        int      burst_left;

        // Key pool: the zero key, all ones, pairs that share the upper half,
        // keys with one half zero, and random keys.
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_high[k] = (k % 2 == 1 && k > 5) ? pool_high[k - 1] : {$urandom, $urandom};
            pool_low[k]  = {$urandom, $urandom};
        end
        pool_high[0] = '0;
        pool_low[0]  = '0;
        pool_high[1] = '1;
        pool_low[1]  = '1;
        pool_high[4] = '0;
        pool_low[5]  = '0;

        for (int i = 0; i < ENTRIES; i++) begin
            slot_high[i] = '0;
            slot_low[i]  = '0;
        end
        used_len = 0;

        build_directed();
        build_random();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Items go out in bursts of random length with random gaps between
        // them; now and then a long burst gives a stretch with no idling.
        burst_left = 0;
        foreach (stim_items[n]) begin
            it = stim_items[n];
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 12);
            end
            i_func          <= it.func;
            i_key_high      <= it.key_high;
            i_key_low       <= it.key_low;
            i_descriptor_in <= it.desc;
            i_valid         <= 1'b1;
            // The item is taken at the first edge where the block does not stall.
            do @(posedge i_clk); while (o_stall);
            got = table_apply(it.func, it.key_high, it.key_low, it.desc);
            answers_due.insert(answers_due.size(), it.fixed ? it.answer : got);
            burst_left--;
        end
        i_valid <= 1'b0;

        // Wait for every owed result, then a little longer so that a stray
        // extra result would still be seen.
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
